### rtl/core/kwl_pkg.sv
// kwl_pkg: shared types and constants of the keyword token lexer
// token record, token kinds, character codes and keyword patterns
// no dependencies
package kwl_pkg;

  localparam int MAX_WORD_CHARS_DEF = 8;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [30:0] INT_MAX31 = 31'h7FFF_FFFF;

  localparam logic [7:0] CHR_SEMI = 8'd59;
  localparam logic [7:0] CHR_EQ = 8'd61;
  localparam logic [7:0] CHR_PLUS = 8'd43;
  localparam logic [7:0] CHR_ZERO = 8'd48;

  localparam logic [63:0] KW_EXIT = 64'h0000_0000_7469_7865;
  localparam logic [63:0] KW_LET = 64'h0000_0000_0074_656C;

  typedef enum logic [2:0] {
    KIND_INT   = 3'd0,
    KIND_SEMI  = 3'd1,
    KIND_EXIT  = 3'd2,
    KIND_LET   = 3'd3,
    KIND_EQ    = 3'd4,
    KIND_PLUS  = 3'd5,
    KIND_OTHER = 3'd6
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [30:0] num_value;
    logic        int_saturated;
    logic [63:0] text;
    logic [7:0]  length;
    logic        truncated;
    logic        last;
  } token_t;

  typedef struct packed {
    logic [1:0] cnt;
    token_t     tok0;
    token_t     tok1;
  } push_t;

endpackage

### rtl/core/kwl_word.sv
// kwl_word: pending word state, character classing and token forming
// produces up to two tokens per accepted item for the output queue
// depends on kwl_pkg
module kwl_word
  import kwl_pkg::*;
#(
  parameter int MAX_WORD_CHARS = MAX_WORD_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] char_byte,
  input  logic       end_of_input,
  output push_t      push
);

  logic [7:0]  chars_r [MAX_WORD_CHARS];
  logic [7:0]  chars_nxt [MAX_WORD_CHARS];
  logic [7:0]  count_r, count_nxt;
  logic        lead_r, lead_nxt;
  logic        run_r, run_nxt;
  logic [30:0] value_r, value_nxt;
  logic        clamp_r, clamp_nxt;

  logic        is_digit, is_alnum, is_space, is_punct;
  logic [63:0] text;
  logic [34:0] prod;
  logic        flush, clear;
  token_t      word_tok, punct_tok;
  logic        punct_vld;

  always_comb begin
    is_digit = (char_byte >= 8'd48) && (char_byte <= 8'd57);
    is_alnum = is_digit || ((char_byte >= 8'd65) && (char_byte <= 8'd90)) ||
               ((char_byte >= 8'd97) && (char_byte <= 8'd122));
    is_space = ((char_byte >= 8'd9) && (char_byte <= 8'd13)) || (char_byte == 8'd32);
    is_punct = ((char_byte >= 8'd33) && (char_byte <= 8'd47)) ||
               ((char_byte >= 8'd58) && (char_byte <= 8'd64)) ||
               ((char_byte >= 8'd91) && (char_byte <= 8'd96)) ||
               ((char_byte >= 8'd123) && (char_byte <= 8'd126));
  end

  always_comb begin
    text = '0;
    for (int i = 0; i < MAX_WORD_CHARS; i++) begin
      text[8*i +: 8] = chars_r[i];
    end
  end

  // word token from current state
  always_comb begin
    word_tok.num_value = '0;
    word_tok.int_saturated = 1'b0;
    word_tok.text = text;
    word_tok.length = count_r;
    word_tok.truncated = count_r > 8'(MAX_WORD_CHARS);
    word_tok.last = 1'b1;
    if (lead_r) begin
      word_tok.kind = KIND_INT;
      word_tok.num_value = value_r;
      word_tok.int_saturated = clamp_r;
    end else if (count_r == 8'd4 && text == KW_EXIT) begin
      word_tok.kind = KIND_EXIT;
    end else if (count_r == 8'd3 && text == KW_LET) begin
      word_tok.kind = KIND_LET;
    end else begin
      word_tok.kind = KIND_OTHER;
    end
  end

  always_comb begin
    punct_tok.num_value = '0;
    punct_tok.int_saturated = 1'b0;
    punct_tok.text = {56'd0, char_byte};
    punct_tok.length = 8'd1;
    punct_tok.truncated = 1'b0;
    punct_tok.last = 1'b1;
    case (char_byte)
      CHR_SEMI: punct_tok.kind = KIND_SEMI;
      CHR_EQ:   punct_tok.kind = KIND_EQ;
      CHR_PLUS: punct_tok.kind = KIND_PLUS;
      default:  punct_tok.kind = KIND_OTHER;
    endcase
  end

  always_comb begin
    flush = (end_of_input || is_space || is_punct) && (count_r != 8'd0);
    clear = end_of_input || flush;
    punct_vld = !end_of_input && is_punct;

    push.cnt = 2'(flush) + 2'(punct_vld);
    push.tok0 = flush ? word_tok : punct_tok;
    push.tok0.last = flush ? !punct_vld : 1'b1;
    push.tok1 = punct_tok;
  end

  // times ten as two shifts plus the new digit
  assign prod = ({4'd0, value_r} << 3) + ({4'd0, value_r} << 1) +
                {27'd0, char_byte - CHR_ZERO};

  always_comb begin
    chars_nxt = chars_r;
    count_nxt = count_r;
    lead_nxt = lead_r;
    run_nxt = run_r;
    value_nxt = value_r;
    clamp_nxt = clamp_r;
    if (take) begin
      if (clear) begin
        for (int i = 0; i < MAX_WORD_CHARS; i++) begin
          chars_nxt[i] = '0;
        end
        count_nxt = '0;
        lead_nxt = 1'b0;
        run_nxt = 1'b1;
        value_nxt = '0;
        clamp_nxt = 1'b0;
      end else if (is_alnum) begin
        for (int i = 0; i < MAX_WORD_CHARS; i++) begin
          if (count_r == 8'(i)) begin
            chars_nxt[i] = char_byte;
          end
        end
        if (is_digit && run_r) begin
          if (count_r == 8'd0) begin
            lead_nxt = 1'b1;
          end
          if (prod > {4'd0, INT_MAX31}) begin
            value_nxt = INT_MAX31;
            clamp_nxt = 1'b1;
          end else begin
            value_nxt = prod[30:0];
          end
        end else begin
          run_nxt = 1'b0;
        end
        if (count_r != 8'd255) begin
          count_nxt = count_r + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_WORD_CHARS; i++) begin
        chars_r[i] <= '0;
      end
      count_r <= '0;
      lead_r <= 1'b0;
      run_r <= 1'b1;
      value_r <= '0;
      clamp_r <= 1'b0;
    end else begin
      chars_r <= chars_nxt;
      count_r <= count_nxt;
      lead_r <= lead_nxt;
      run_r <= run_nxt;
      value_r <= value_nxt;
      clamp_r <= clamp_nxt;
    end
  end

endmodule

### rtl/core/kwl_out_fifo.sv
// kwl_out_fifo: small token queue taking up to two tokens per cycle
// hands one token per cycle to the result channel while rd_en is high
// depends on kwl_pkg
module kwl_out_fifo
  import kwl_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   wr_en,
  input  push_t  push,
  output logic   room2,
  input  logic   rd_en,
  output logic   not_empty,
  output token_t head
);

  token_t                mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [FIFO_PTR_W:0]   cnt_r, cnt_nxt;
  logic [1:0]            n_wr;

  assign n_wr = wr_en ? push.cnt : 2'd0;
  assign room2 = cnt_r <= (FIFO_PTR_W+1)'(FIFO_DEPTH - 2);
  assign not_empty = cnt_r != '0;
  assign head = mem_r[rp_r];

  always_comb begin
    wp_nxt = wp_r + FIFO_PTR_W'(n_wr);
    rp_nxt = rp_r + FIFO_PTR_W'(rd_en);
    cnt_nxt = cnt_r + (FIFO_PTR_W+1)'(n_wr) - (FIFO_PTR_W+1)'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (n_wr != 2'd0) begin
      mem_r[wp_r] <= push.tok0;
    end
    if (n_wr == 2'd2) begin
      mem_r[wp_r + FIFO_PTR_W'(1)] <= push.tok1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### rtl/core/keyword_token_lexer.sv
// keyword_token_lexer: byte-serial lexer for words, integers and punctuation
// a token is written into the token queue when the item that completes it is taken
// throughput: one item per cycle; an item giving two tokens leaves one in the
// four-entry token queue, and in_stall rises while fewer than two slots are free
// reset: synchronous, clears the pending word and empties the token queue
// depends on kwl_pkg, kwl_word, kwl_out_fifo
module keyword_token_lexer
  import kwl_pkg::*;
#(
  parameter int MAX_WORD_CHARS = MAX_WORD_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_byte,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_token_kind,
  output logic [30:0] out_num_value,
  output logic        out_int_saturated,
  output logic [63:0] out_token_text,
  output logic [7:0]  out_text_length,
  output logic        out_text_truncated,
  output logic        out_last_of_run
);

  logic   take, room2;
  push_t  push;
  token_t head;

  assign in_stall = !room2;
  assign take = in_valid && room2;

  kwl_word #(
    .MAX_WORD_CHARS(MAX_WORD_CHARS)
  ) u_word (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .char_byte    (in_char_byte),
    .end_of_input (in_end_of_input),
    .push         (push)
  );

  kwl_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (take),
    .push      (push),
    .room2     (room2),
    .rd_en     (out_valid && !out_stall),
    .not_empty (out_valid),
    .head      (head)
  );

  assign out_token_kind = head.kind;
  assign out_num_value = head.num_value;
  assign out_int_saturated = head.int_saturated;
  assign out_token_text = head.text;
  assign out_text_length = head.length;
  assign out_text_truncated = head.truncated;
  assign out_last_of_run = head.last;

endmodule
